### design/sra_pkg.sv
// Shared types, constants and helper functions for the score averaging and ranking block.
// No dependencies; every other file of the block except sra_ram imports this package.
`timescale 1ns / 1ps

package sra_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int SCORE_W         = 32;
    localparam int SUM_W           = 34;
    localparam int AVG_W           = 32;
    localparam int OUT_IDX_W       = 6;
    localparam int QUEUE_DEPTH     = 2;

    // Divide-by-three unit: four quotient bits per cycle over a padded magnitude.
    localparam int DIV_STEP  = 4;
    localparam int DIV_W     = 36;
    localparam int DIV_ITERS = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);

    typedef struct packed {
        logic signed [SCORE_W-1:0] score_a;
        logic signed [SCORE_W-1:0] score_b;
        logic signed [SCORE_W-1:0] score_c;
        logic                      is_last;
    } item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]    entry_index;
        logic [OUT_IDX_W-1:0]    rank;
        logic signed [AVG_W-1:0] average;
        logic                    truncated;
        logic                    last_result;
    } result_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    is_last;
    } qentry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_CAPT,
        ST_SWEEP,
        ST_EMIT
    } back_state_t;

    // Four steps of restoring division by three. Returns {remainder, quotient bits}.
    function automatic logic [DIV_STEP+1:0] div3_step(input logic [1:0] rem_in,
                                                      input logic [DIV_STEP-1:0] bits);
        logic [2:0]          r;
        logic [1:0]          rem;
        logic [DIV_STEP-1:0] q;
        rem = rem_in;
        q   = '0;
        for (int k = DIV_STEP - 1; k >= 0; k--) begin
            r = {rem, bits[k]};
            if (r >= 3'd3) begin
                q[k] = 1'b1;
                r    = r - 3'd3;
            end
            rem = r[1:0];
        end
        return {rem, q};
    endfunction

endpackage

### design/sra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sra_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/sra_front.sv
// Front end: takes a word whenever start is high and busy is low, forms the exact 34-bit score sum.
// Depends on sra_pkg; feeds the queue ahead of the ranking back end.
`timescale 1ns / 1ps

module sra_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sra_pkg::item_t  item,
    output logic            push,
    output sra_pkg::qentry_t push_data,
    input  logic            full
);

    import sra_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    qentry_t data_reg;
    qentry_t data_next;
    logic    accept;

    assign busy   = valid_reg && full;
    assign accept = start && !busy;
    assign push   = valid_reg && !full;
    assign push_data = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept)
        begin
            valid_next        = 1'b1;
            data_next.sum     = SUM_W'(item.score_a) + SUM_W'(item.score_b)
                              + SUM_W'(item.score_c);
            data_next.is_last = item.is_last;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### design/sra_queue.sv
// Short queue of summed words between the front end and the ranking back end.
// Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sra_pkg::qentry_t push_data,
    output logic             full,
    input  logic             pop,
    output sra_pkg::qentry_t pop_data,
    output logic             empty
);

    import sra_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qentry_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### design/sra_back.sv
// Back end: stores sums of the row, then ranks and averages every entry in order.
// Depends on sra_pkg and sra_ram (the sum store).
`timescale 1ns / 1ps

module sra_back #(
    parameter int MAX_ENTRIES = sra_pkg::MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  sra_pkg::qentry_t q_data,
    output logic             q_pop,
    output logic             strobe,
    output sra_pkg::result_t result
);

    import sra_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [IDX_W-1:0]    j_reg;
    logic [IDX_W-1:0]    j_next;
    logic [CNT_W-1:0]    i_reg;
    logic [CNT_W-1:0]    i_next;
    logic                pend_reg;
    logic                pend_next;
    logic [CNT_W-1:0]    smaller_reg;
    logic [CNT_W-1:0]    smaller_next;
    logic signed [SUM_W-1:0] sj_reg;
    logic signed [SUM_W-1:0] sj_next;
    logic                neg_reg;
    logic                neg_next;
    logic [DIV_W-1:0]    num_reg;
    logic [DIV_W-1:0]    num_next;
    logic [DIV_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    quo_next;
    logic [1:0]          rem_reg;
    logic [1:0]          rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic                strobe_reg;
    logic                strobe_next;
    result_t             result_reg;
    result_t             result_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [SUM_W-1:0]    ram_rdata;

    logic                sweep_done;
    logic                div_done;
    logic                j_last;
    logic [SUM_W-1:0]    mag;
    logic [DIV_STEP+1:0] step;
    logic [AVG_W-1:0]    avg_mag;

    sra_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_sum_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_data.sum),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sweep_done = (i_reg == cnt_reg) && !pend_reg;
    assign div_done   = (div_cnt_reg == '0);
    assign j_last     = (CNT_W'(j_reg) + 1'b1 == cnt_reg);
    assign mag        = ram_rdata[SUM_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
    assign step       = div3_step(rem_reg, num_reg[DIV_W-1 -: DIV_STEP]);
    assign avg_mag    = quo_reg[AVG_W-1:0];
    assign strobe     = strobe_reg;
    assign result     = result_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (!q_empty && q_data.is_last)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (sweep_done && div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = j_last ? ST_LOAD : ST_FETCH;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        pend_next    = 1'b0;
        smaller_next = smaller_reg;
        sj_next      = sj_reg;
        neg_next     = neg_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[IDX_W-1:0];
        ram_raddr    = j_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (cnt_reg < CNT_W'(MAX_ENTRIES))
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    j_next = '0;
                end
            end
            ST_FETCH:
            begin
                ram_raddr = j_reg;
                i_next    = '0;
            end
            ST_CAPT:
            begin
                sj_next      = ram_rdata;
                neg_next     = ram_rdata[SUM_W-1];
                num_next     = DIV_W'(mag);
                quo_next     = '0;
                rem_next     = '0;
                div_cnt_next = DIV_CNT_W'(DIV_ITERS);
                smaller_next = '0;
            end
            ST_SWEEP:
            begin
                // Issue one read per cycle; the compare sees its data in the following cycle.
                if (i_reg != cnt_reg)
                begin
                    ram_raddr = i_reg[IDX_W-1:0];
                    i_next    = i_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && ($signed(ram_rdata) < sj_reg))
                begin
                    smaller_next = smaller_reg + 1'b1;
                end
                if (!div_done)
                begin
                    num_next     = num_reg << DIV_STEP;
                    quo_next     = {quo_reg[DIV_W-DIV_STEP-1:0], step[DIV_STEP-1:0]};
                    rem_next     = step[DIV_STEP+1:DIV_STEP];
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                strobe_next             = 1'b1;
                result_next.entry_index = OUT_IDX_W'(j_reg);
                result_next.rank        = OUT_IDX_W'(cnt_reg - 1'b1 - smaller_reg);
                result_next.average     = neg_reg ? (~avg_mag + 1'b1) : avg_mag;
                result_next.truncated   = ovf_reg;
                result_next.last_result = j_last;
                if (j_last)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            j_reg       <= '0;
            i_reg       <= '0;
            pend_reg    <= 1'b0;
            div_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            j_reg       <= j_next;
            i_reg       <= i_next;
            pend_reg    <= pend_next;
            div_cnt_reg <= div_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smaller_reg <= smaller_next;
        sj_reg      <= sj_next;
        neg_reg     <= neg_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        result_reg  <= result_next;
    end

endmodule

### design/score_average_rank.sv
// Top level of the score averaging and ranking block.
// Depends on sra_pkg, sra_front, sra_queue and sra_back (which holds sra_ram).
`timescale 1ns / 1ps

// Each word carries three signed Q15.16 scores; words are taken whenever start is high
// and busy is low. The front end registers the exact sum and passes it through a
// two-word queue, so during loading one word per cycle is accepted. When the word marked
// is_last reaches the back end, one result per stored entry is strobed out in load
// order; results cannot be held off, so strobe must be sampled every cycle. Ranking
// reads the sum memory once per cycle through its single read port, comparing each
// entry's sum with every stored sum of the row. Words that arrive meanwhile fill the
// queue, after which busy stays high until ranking ends. Words beyond MAX_ENTRIES in
// one row are dropped and flag truncated in that row.
module score_average_rank #(
    parameter int MAX_ENTRIES = sra_pkg::MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sra_pkg::item_t   item,
    output logic             strobe,
    output sra_pkg::result_t result
);

    import sra_pkg::*;

    logic    push;
    logic    full;
    logic    pop;
    logic    empty;
    qentry_t push_data;
    qentry_t pop_data;

    sra_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    sra_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sra_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (empty),
        .q_data  (pop_data),
        .q_pop   (pop),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

### tb/score_average_rank_tb.sv
// Self-checking testbench for score_average_rank: loads rows of score words, predicts
// every ranked result in the testbench itself and compares each strobed result in order.
// Depends on sra_pkg and the score_average_rank RTL; needs no other files.
`timescale 1ns / 1ps

module score_average_rank_tb;

    import sra_pkg::*;

    localparam int ROW_CAP        = MAX_ENTRIES_DEF;
    localparam int RANDOM_WORDS   = 150;
    localparam int QUIET_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = 200;
    localparam int RESET_CYCLES   = 11;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef struct {
        item_t word;
        bit    wait_empty;
    } pending_t;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    strobe;
    result_t result;

    pending_t pending_words[$];
    result_t  expected_results[$];

    // Predicted row contents: exact 34-bit sums in load order.
    logic signed [SUM_W-1:0] row_sums [ROW_CAP];
    int row_count;
    bit row_overflow;

    int  errors;
    int  results_checked;
    int  words_accepted;
    int  rows_done;
    int  rows_truncated;
    int  quiet_cycles;
    int  burst_left;
    int  gap_left;
    logic word_taken = 1'b0;

    score_average_rank dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void record_word(input item_t w);
        longint  total;
        result_t r;
        int      smaller;
        total = longint'(w.score_a) + longint'(w.score_b) + longint'(w.score_c);
        if (row_count < ROW_CAP)
        begin
            row_sums[row_count] = total[SUM_W-1:0];
            row_count++;
        end
        else
        begin
            row_overflow = 1'b1;
        end
        if (w.is_last)
        begin
            rows_done++;
            if (row_overflow)
                rows_truncated++;
            for (int j = 0; j < row_count; j++)
            begin
                smaller = 0;
                for (int i = 0; i < row_count; i++)
                    if (row_sums[i] < row_sums[j])
                        smaller++;
                r.entry_index = OUT_IDX_W'(j);
                r.rank        = OUT_IDX_W'(row_count - 1 - smaller);
                r.average     = AVG_W'(longint'(row_sums[j]) / 3);
                r.truncated   = row_overflow;
                r.last_result = (j == row_count - 1);
                expected_results.push_back(r);
            end
            row_count    = 0;
            row_overflow = 1'b0;
        end
    endfunction

    function automatic void check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with none expected: entry_index %0d rank %0d average %0d",
                   got.entry_index, got.rank, got.average);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (got.entry_index !== want.entry_index)
        begin
            $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
            errors++;
        end
        if (got.rank !== want.rank)
        begin
            $error("rank: expected %0d, got %0d", want.rank, got.rank);
            errors++;
        end
        if (got.average !== want.average)
        begin
            $error("average: expected %0d, got %0d", want.average, got.average);
            errors++;
        end
        if (got.truncated !== want.truncated)
        begin
            $error("truncated: expected %0b, got %0b", want.truncated, got.truncated);
            errors++;
        end
        if (got.last_result !== want.last_result)
        begin
            $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
            errors++;
        end
    endfunction

    task automatic enqueue_word(input logic signed [SCORE_W-1:0] a,
                                input logic signed [SCORE_W-1:0] b,
                                input logic signed [SCORE_W-1:0] c,
                                input bit last, input bit wait_empty);
        pending_t p;
        p.word.score_a = a;
        p.word.score_b = b;
        p.word.score_c = c;
        p.word.is_last = last;
        p.wait_empty   = wait_empty;
        pending_words.push_back(p);
    endtask

    // Mixes full-range values with extremes and a small pool that makes ties likely.
    function automatic logic signed [SCORE_W-1:0] score_pick();
        case ($urandom_range(0, 7))
            0:       return SCORE_MAX;
            1:       return SCORE_MIN;
            2, 3:    return SCORE_W'($signed($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_row(input int len, input bit wait_empty);
        for (int k = 0; k < len; k++)
            enqueue_word(score_pick(), score_pick(), score_pick(), k == len - 1,
                         wait_empty && k == 0);
    endtask

    // Sampling side: accepted words feed the predictor, strobed results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= start && !busy;
            if (strobe)
                check_result(result);
            if (start && !busy)
            begin
                record_word(item);
                words_accepted++;
            end
        end
    end

    // Sending side: bursts of words with random gaps, one assignment per signal per edge.
    always @(negedge clk)
    begin : drive_words
        logic     next_start;
        item_t    next_word;
        pending_t next_pend;
        next_start = start;
        next_word  = item;
        if (rst_n)
        begin
            if (word_taken)
                next_start = 1'b0;
            if (!next_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].wait_empty && expected_results.size() != 0))
                begin
                    next_pend  = pending_words.pop_front();
                    next_word  = next_pend.word;
                    next_start = 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        start <= next_start;
        item  <= next_word;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: %0d quiet cycles, %0d results still expected",
                         quiet_cycles, expected_results.size());
                $display("[score_average_rank] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        int random_count;
        int row_no;
        int len;

        // A single entry at each extreme.
        enqueue_word(SCORE_MAX, SCORE_MAX, SCORE_MAX, 1'b1, 1'b0);
        enqueue_word(SCORE_MIN, SCORE_MIN, SCORE_MIN, 1'b1, 1'b0);
        // Sums of -1, 2, -2 all average to zero but rank apart; the two sums of 2 tie.
        enqueue_word(SCORE_MAX, SCORE_MIN, 0, 1'b0, 1'b0);
        enqueue_word(1, 1, 0, 1'b0, 1'b0);
        enqueue_word(-1, -1, -1, 1'b0, 1'b0);
        enqueue_word(0, 0, 0, 1'b0, 1'b0);
        enqueue_word(2, 0, 0, 1'b0, 1'b0);
        enqueue_word(-2, 0, 0, 1'b0, 1'b0);
        enqueue_word(SCORE_MIN, SCORE_MAX, SCORE_MIN, 1'b0, 1'b0);
        enqueue_word(SCORE_MAX, SCORE_MIN, SCORE_MAX, 1'b1, 1'b0);
        // All entries equal; the sender first waits for the previous row to drain.
        enqueue_word(5, 5, 5, 1'b0, 1'b1);
        enqueue_word(5, 5, 5, 1'b0, 1'b0);
        enqueue_word(5, 5, 5, 1'b0, 1'b0);
        enqueue_word(5, 5, 5, 1'b1, 1'b0);

        // Random rows, mostly short, with one exactly full row and one that
        // overflows so that its closing word is itself dropped.
        random_count = 0;
        row_no       = 0;
        while (random_count < RANDOM_WORDS || row_no <= 6)
        begin
            if (row_no == 3)
                len = ROW_CAP;
            else if (row_no == 6)
                len = ROW_CAP + 2;
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(1, 6);
            add_random_row(len, $urandom_range(0, 7) == 0);
            random_count += len;
            row_no++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || start)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("Loaded %0d words in %0d rows, %0d of them past capacity.",
                 words_accepted, rows_done, rows_truncated);
        $display("Compared %0d ranked results; %0d mismatches.", results_checked, errors);
        if (errors == 0)
            $display("[score_average_rank] OK");
        else
            $display("[score_average_rank] ERROR");
        $finish;
    end

endmodule

### sim.f
design/sra_pkg.sv
design/sra_ram.sv
design/sra_front.sv
design/sra_queue.sv
design/sra_back.sv
design/score_average_rank.sv
tb/score_average_rank_tb.sv
